// ----- sv/mip_level_crisp_downsample_core_macros.svh -----
// Assertion macros shared by the mip-level downsampler RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MIP_LEVEL_CRISP_DOWNSAMPLE_CORE_MACROS_SVH
`define MIP_LEVEL_CRISP_DOWNSAMPLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MIPDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MIPDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mipds_pkg.sv -----
// Shared types, constants and blend functions for the mip-level downsampler.
// No dependencies; used by mipds_ram, the top level and the bench.
`default_nettype none

package mipds_pkg;

  localparam int TEXEL_W         = 32;
  localparam int BYTE_W          = 8;
  localparam int SRC_WIDTH_W     = 12;
  localparam int CFG_DATA_W      = 12;
  localparam int CFG_IDX_W       = 1;
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int SRC_WIDTH_RESET = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_BGRA = 1'b1;

  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam byte_t ALPHA_OPAQUE = 8'hff;
  localparam byte_t ALPHA_CLEAR  = 8'h00;

  // Move alpha from the low byte to the high byte: RGBA becomes ARGB.
  function automatic texel_t rgba_to_argb(input texel_t v);
    return {v[7:0], v[31:8]};
  endfunction

  // One color channel of a crisp blend. The average case halves the sum;
  // otherwise the strong channel is weighted 255 and the weak one 1.
  function automatic byte_t crisp_chan(input byte_t cp, input byte_t cq,
                                       input logic avg, input logic p_strong);
    logic [8:0]  sum;
    logic [15:0] acc;
    byte_t       s;
    byte_t       w;
    sum = {1'b0, cp} + {1'b0, cq};
    s   = p_strong ? cp : cq;
    w   = p_strong ? cq : cp;
    acc = {s, 8'h00} - {8'h00, s} + {8'h00, w};
    return avg ? sum[8:1] : acc[15:8];
  endfunction

  // Crisp blend of two ARGB texels. On equal alphas q is the strong one.
  function automatic texel_t crisp_blend(input texel_t p, input texel_t q);
    logic [8:0] asum;
    logic       avg;
    logic       p_strong;
    asum     = {1'b0, p[31:24]} + {1'b0, q[31:24]};
    avg      = (asum < 9'(ALPHA_OPAQUE));
    p_strong = (p[31:24] > q[31:24]);
    return {avg ? ALPHA_CLEAR : ALPHA_OPAQUE,
            crisp_chan(p[23:16], q[23:16], avg, p_strong),
            crisp_chan(p[15:8],  q[15:8],  avg, p_strong),
            crisp_chan(p[7:0],   q[7:0],   avg, p_strong)};
  endfunction

endpackage

`default_nettype wire

// ----- sv/mipds_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Uses mipds_pkg only for the default data width and depth.
`default_nettype none

module mipds_ram #(
  parameter int WIDTH = mipds_pkg::TEXEL_W,
  parameter int DEPTH = mipds_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/mip_level_crisp_downsample_core.sv -----
// Top level of the 2x2 crisp mip-level downsampler.
// Depends on mipds_pkg, mipds_ram and mip_level_crisp_downsample_core_macros.svh.
//
//   Channel   Direction  Handshake          Beat contents
//   in_       in         in_valid/in_ready  in_texel: one RGBA source texel
//   out_      out        out_valid/out_ready out_byte0..3: one result texel
//   cfg_      in         cfg_we             cfg_index, cfg_wdata: register write
//
// One beat is accepted per cycle while in_ready is high. The beat that
// completes a 2x2 block reads the line store and blends the pair into the
// middle stage; the final blend then goes into the output register.
// Reset is synchronous and clears position, row parity, valids and config registers.
// A stalled output blocks input only while a result also waits in the middle
// stage; beats that give no result keep flowing behind a single waiting one.
`default_nettype none

`include "mip_level_crisp_downsample_core_macros.svh"

module mip_level_crisp_downsample_core #(
  parameter int MAX_WIDTH = mipds_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mipds_pkg::texel_t                 in_texel,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mipds_pkg::byte_t                       out_byte0,
  output mipds_pkg::byte_t                       out_byte1,
  output mipds_pkg::byte_t                       out_byte2,
  output mipds_pkg::byte_t                       out_byte3,
  input  wire logic                              cfg_we,
  input  wire logic [mipds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mipds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import mipds_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CCW   = $clog2(MAX_WIDTH);
  localparam int EW    = ($clog2(MAX_WIDTH + 1) > SRC_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : SRC_WIDTH_W;
  localparam int MAXW_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int RST_W0    = SRC_WIDTH_RESET - (SRC_WIDTH_RESET % 2);
  localparam int RST_W1    = (RST_W0 < 2) ? 2 : RST_W0;
  localparam int RST_W     = (RST_W1 > MAXW_EVEN) ? MAXW_EVEN : RST_W1;
  localparam logic [CCW-1:0] LAST_COL_RST = CCW'(RST_W - 1);
  localparam logic [EW-1:0]  MAXW_E       = EW'(MAXW_EVEN);
  localparam logic [EW-1:0]  MINW_E       = EW'(2);

  // Configuration state.
  logic [CCW-1:0] last_col_r, last_col_nxt;
  logic           format_bgra_r;

  // Position state.
  logic [CCW-1:0] col_r, col_nxt;
  logic           odd_row_r, odd_row_nxt;
  texel_t         held_r;

  // Middle stage and output register.
  logic   s1_valid_r, s1_valid_nxt;
  texel_t s1_bot_r;
  logic   out_valid_r, out_valid_nxt;
  byte_t  out_b0_r, out_b1_r, out_b2_r, out_b3_r;

  logic   out_en, s1_en, accept, odd_col, row_end;
  logic   ram_we, ram_re;
  logic   [AW-1:0] pair_addr;
  texel_t texel_argb, top_blend, bot_blend, ram_rdata, final_col;
  logic   [EW-1:0] w_req, w_lo, w_clamped;

  // Clamp the requested width to an even value in [2, MAX_WIDTH] and keep
  // the index of the last column.
  always_comb begin
    w_req        = EW'({cfg_wdata[SRC_WIDTH_W-1:1], 1'b0});
    w_lo         = (w_req < MINW_E) ? MINW_E : w_req;
    w_clamped    = (w_lo > MAXW_E) ? MAXW_E : w_lo;
    last_col_nxt = last_col_r;
    if (cfg_we && (cfg_index == CFG_SRC_WIDTH)) begin
      last_col_nxt = CCW'(w_clamped - EW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r    <= LAST_COL_RST;
      format_bgra_r <= 1'b0;
    end else begin
      last_col_r <= last_col_nxt;
      if (cfg_we && (cfg_index == CFG_FORMAT_BGRA)) begin
        format_bgra_r <= cfg_wdata[0];
      end
    end
  end

  // Handshake: the output register frees the middle stage, which frees the input.
  assign out_en   = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_ready = s1_en;
  assign accept   = in_valid && s1_en;

  // Column and row tracking; the row ends at or past the last column.
  assign odd_col = col_r[0];
  assign row_end = (col_r >= last_col_r);

  always_comb begin
    col_nxt     = col_r;
    odd_row_nxt = odd_row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt     = '0;
        odd_row_nxt = !odd_row_r;
      end else begin
        col_nxt = col_r + CCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      odd_row_r <= 1'b0;
      held_r    <= '0;
    end else begin
      col_r     <= col_nxt;
      odd_row_r <= odd_row_nxt;
      if (accept && !odd_col) begin
        held_r <= texel_argb;
      end
    end
  end

  // Pair blends: the top row's go to the line store, the bottom row's wait
  // in the middle stage for the stored top pair.
  assign texel_argb = rgba_to_argb(in_texel);
  assign top_blend  = crisp_blend(held_r, texel_argb);
  assign bot_blend  = crisp_blend(texel_argb, held_r);
  assign pair_addr  = col_r[AW:1];
  assign ram_we     = accept && odd_col && !odd_row_r;
  assign ram_re     = accept && odd_col && odd_row_r;

  mipds_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pair_addr),
    .wdata (top_blend),
    .re    (ram_re),
    .raddr (pair_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_en) begin
      s1_valid_nxt = ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_bot_r <= bot_blend;
    end
  end

  // Final blend and byte order into the output register.
  assign final_col = crisp_blend(ram_rdata, s1_bot_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_en) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_b0_r <= format_bgra_r ? final_col[7:0] : final_col[23:16];
      out_b1_r <= final_col[15:8];
      out_b2_r <= format_bgra_r ? final_col[23:16] : final_col[7:0];
      out_b3_r <= final_col[31:24];
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte0 = out_b0_r;
  assign out_byte1 = out_b1_r;
  assign out_byte2 = out_b2_r;
  assign out_byte3 = out_b3_r;

  // Checks on the pipeline and line-store control.
  `MIPDS_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_ready, !in_ready,
    "input accepted while both result stages are stalled")

  `MIPDS_ASSERT_NOW(a_read_on_bottom_odd, clk, rst_n,
    ram_re, odd_row_r && odd_col && !ram_we,
    "line store read outside the second beat of a bottom-row pair")

  `MIPDS_ASSERT_NEXT(a_read_fills_stage, clk, rst_n,
    ram_re, s1_valid_r,
    "line store read did not load the middle stage")

  `MIPDS_ASSERT_NOW(a_out_from_stage, clk, rst_n,
    $rose(out_valid_r), $past(s1_valid_r),
    "result appeared without a pending middle-stage item")

endmodule

`default_nettype wire

// ----- bench/mip_level_crisp_downsample_core_test.sv -----
// Self-checking bench for the 2x2 crisp mip-level downsampler core.
// Drives raster texel beats, predicts each result texel in-line and checks the output beats.
// Depends on mipds_pkg and mip_level_crisp_downsample_core.
`default_nettype none

module mip_level_crisp_downsample_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX   = mipds_pkg::MAX_WIDTH_DEF;
  localparam int unsigned PAIR_SLOTS = LINE_MAX / 2;
  localparam int unsigned LONG_HOLD  = 400;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } result_texel_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  mipds_pkg::texel_t                     in_texel = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  mipds_pkg::byte_t                      out_byte0;
  mipds_pkg::byte_t                      out_byte1;
  mipds_pkg::byte_t                      out_byte2;
  mipds_pkg::byte_t                      out_byte3;
  logic                                  cfg_we = 1'b0;
  logic [mipds_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [mipds_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

  // Predictor state: line store of top-row pair blends, position and registers.
  logic [31:0]  line_pairs [0:PAIR_SLOTS-1];
  logic [31:0]  held_argb;
  int unsigned  col_pos;
  bit           odd_line;
  logic [11:0]  reg_width;
  bit           reg_bgra;

  // Bench bookkeeping.
  logic [31:0]   source_texels [$];
  result_texel_t texels_due [$];
  int unsigned   beats_queued = 0;
  int unsigned   beats_taken = 0;
  int unsigned   error_count = 0;
  int unsigned   tx_wait = 0;
  int unsigned   rx_wait = 0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  int unsigned   hold_asked = 0;
  int unsigned   hold_given = 0;
  logic [7:0]    last_alpha = 8'h00;

  mip_level_crisp_downsample_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_texel  (in_texel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .out_byte3 (out_byte3),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Row width the block actually uses: even, at least 2, at most the line size.
  function automatic int unsigned active_width();
    int unsigned w;
    w = 32'({reg_width[11:1], 1'b0});
    if (w < 2) w = 2;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  // Crisp blend of two ARGB words; on equal alphas q carries the weight.
  function automatic logic [31:0] crisp_mix(input logic [31:0] p, input logic [31:0] q);
    int unsigned ap;
    int unsigned aq;
    int unsigned wp;
    int unsigned wq;
    int unsigned sh;
    int unsigned c;
    logic [31:0] res;
    ap = 32'(p[31:24]);
    aq = 32'(q[31:24]);
    if (ap + aq < 255) begin
      wp = 1; wq = 1; sh = 1; res = 32'h0000_0000;
    end else if (ap > aq) begin
      wp = 255; wq = 1; sh = 8; res = 32'hff00_0000;
    end else begin
      wp = 1; wq = 255; sh = 8; res = 32'hff00_0000;
    end
    for (int s = 0; s < 3; s++) begin
      c = (int'(p[8*s +: 8]) * wp + int'(q[8*s +: 8]) * wq) >> sh;
      res[8*s +: 8] = c[7:0];
    end
    return res;
  endfunction

  // Advance the predictor by one accepted source texel.
  task automatic absorb_source_texel(input logic [31:0] rgba);
    logic [31:0] argb;
    logic [31:0] mix;
    int unsigned pair;
    int unsigned w;
    result_texel_t r;
    argb = {rgba[7:0], rgba[31:8]};
    w = active_width();
    pair = col_pos >> 1;
    if (col_pos[0] == 1'b0) begin
      held_argb = argb;
    end else if (pair < PAIR_SLOTS) begin
      if (!odd_line) begin
        line_pairs[pair] = crisp_mix(held_argb, argb);
      end else begin
        mix = crisp_mix(line_pairs[pair], crisp_mix(argb, held_argb));
        r.b0 = reg_bgra ? mix[7:0] : mix[23:16];
        r.b1 = mix[15:8];
        r.b2 = reg_bgra ? mix[23:16] : mix[7:0];
        r.b3 = mix[31:24];
        texels_due.push_back(r);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      odd_line = !odd_line;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Mostly short gaps, some medium, a few long; none in steady mode.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // Alpha leans toward the blend thresholds, repeats and the extremes.
  function automatic logic [31:0] pick_texel(input logic [7:0] prev_a);
    logic [7:0]  a;
    logic [23:0] rgb;
    case ($urandom_range(0, 6))
      0: a = 8'h00;
      1: a = 8'hff;
      2: a = 8'h7f;
      3: a = 8'h80;
      4: a = prev_a;
      default: a = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: rgb = 24'hffffff;
      1: rgb = 24'h000000;
      default: rgb = 24'($urandom);
    endcase
    return {rgb, a};
  endfunction

  task automatic queue_texel(input logic [31:0] t);
    source_texels.push_back(t);
    beats_queued++;
  endtask

  task automatic queue_random_texels(input int unsigned n);
    logic [31:0] t;
    for (int unsigned k = 0; k < n; k++) begin
      t = pick_texel(last_alpha);
      last_alpha = t[7:0];
      queue_texel(t);
    end
  endtask

  // One 2x2 block in raster order while the row width is 2.
  task automatic queue_block(input logic [31:0] tl, input logic [31:0] tr,
                             input logic [31:0] bl, input logic [31:0] br);
    queue_texel(tl);
    queue_texel(tr);
    queue_texel(bl);
    queue_texel(br);
  endtask

  task automatic write_reg(input logic [mipds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mipds_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mipds_pkg::CFG_SRC_WIDTH) reg_width = val;
    else reg_bgra = val[0];
  endtask

  // Wait until every beat is taken and every result has come, then let the pipe empty.
  task automatic settle();
    while (beats_taken != beats_queued || texels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Source driver: one beat held until taken, random gaps between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        absorb_source_texel(in_texel);
        beats_taken = beats_taken + 1;
      end
      if (tx_wait != 0) begin
        tx_wait  <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (source_texels.size() != 0) begin
        in_valid <= 1'b1;
        in_texel <= source_texels.pop_front();
        tx_wait  <= pick_gap(tx_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_asked != hold_given) begin
      out_ready  <= 1'b0;
      rx_wait    <= LONG_HOLD;
      hold_given <= hold_given + 1;
    end else if (rx_wait != 0) begin
      out_ready <= 1'b0;
      rx_wait   <= rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_wait <= pick_gap(rx_steady);
    end
  end

  // Result checker against the oldest predicted texel.
  always @(posedge clk) begin
    result_texel_t want;
    result_texel_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_byte0, out_byte1, out_byte2, out_byte3};
      if (texels_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result beat %h arrived with nothing expected", $time, got);
      end else begin
        want = texels_due.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result mismatch: expected %h, got %h", $time, want, got);
        end
      end
    end
  end

  // Stimulus: directed blocks, a mid-row width change, then random frames at varying widths.
  initial begin
    int unsigned sent;
    int unsigned rows;
    int unsigned w;
    int unsigned r;
    int unsigned guard;
    bit          odd_h;
    bit          hold_done;

    held_argb = 32'h0;
    col_pos   = 0;
    odd_line  = 1'b0;
    reg_width = 12'd16;
    reg_bgra  = 1'b0;
    sent      = 0;
    hold_done = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Width below two behaves as two; RGBA order.
    write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'd0);
    write_reg(mipds_pkg::CFG_FORMAT_BGRA, 12'd0);
    // All clear: plain averages.
    queue_block(32'hffffff00, 32'hffffff00, 32'h00000000, 32'hffffff00);
    // Opaque top with equal alphas over a clear bottom.
    queue_block(32'hffffffff, 32'hffffffff, 32'h00000000, 32'h00000000);
    // Alpha sums of exactly 255, strong on either side.
    queue_block(32'h12345680, 32'habcdef7f, 32'hff0000fe, 32'h00ff0001);
    // Alpha sums of 254 stay clear.
    queue_block(32'h11223380, 32'h4455667e, 32'h8080807f, 32'h7f7f7f7f);
    settle();

    // Odd width drops bit 0; BGRA order.
    write_reg(mipds_pkg::CFG_FORMAT_BGRA, 12'd1);
    write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'd3);
    queue_block(32'hdeadbeef, 32'h01234567, 32'h89abcdef, 32'hfedcba98);
    settle();

    // Width shrinks mid-row: the kept position passes the new row end.
    write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'd4);
    queue_random_texels(3);
    settle();
    write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'd2);
    queue_random_texels(3);
    settle();

    // Random frames, phase by phase.
    while (sent < 1500) begin
      // A frame of odd height leaves a bottom row pending; close it at the same width.
      if (odd_line) begin
        queue_random_texels(active_width());
        settle();
      end

      rows  = $urandom_range(1, 4);
      odd_h = ($urandom_range(0, 5) == 0);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);

      if (!hold_done && sent >= 300) begin
        // Long sink hold-off while the source keeps streaming.
        write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'd16);
        rows      = 4;
        odd_h     = 1'b0;
        tx_steady = 1'b1;
        hold_done = 1'b1;
        hold_asked++;
      end else begin
        r = $urandom_range(0, 39);
        if (r < 4) begin
          write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'($urandom_range(25, 160)));
          rows = $urandom_range(1, 2);
        end else if (r < 30) begin
          write_reg(mipds_pkg::CFG_SRC_WIDTH, 12'($urandom_range(0, 24)));
        end
        if ($urandom_range(0, 1) == 0)
          write_reg(mipds_pkg::CFG_FORMAT_BGRA, 12'($urandom_range(0, 1)));
      end

      w = active_width();
      queue_random_texels(2 * w * rows + (odd_h ? w : 0));
      sent += 2 * w * rows + (odd_h ? w : 0);
      settle();
    end

    // Drain with a bound, then judge.
    guard = 0;
    while ((beats_taken != beats_queued || texels_due.size() != 0) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (beats_taken != beats_queued) begin
      error_count++;
      $display("%0d source beats were never taken", beats_queued - beats_taken);
    end
    if (texels_due.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", texels_due.size());
    end
    if (error_count == 0) begin
      $display("mip_level_crisp_downsample_core_test: clean");
    end else begin
      $display("mip_level_crisp_downsample_core_test: errors");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("mip_level_crisp_downsample_core_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
